/* src/pf6_pkg.sv */
package pf6_pkg;

   localparam int SIDE = 6;
   localparam int NSYM = SIDE * SIDE;
   localparam int SYM_W = 6;

   typedef logic [SYM_W-1:0] sym_type;
   typedef logic [2:0]       code_type;
   typedef logic [7:0]       char_type;

   // Command codes of the request word
   localparam code_type CMD_START_KEY = 3'd0;
   localparam code_type CMD_KEY_CHAR  = 3'd1;
   localparam code_type CMD_KEY_END   = 3'd2;
   localparam code_type CMD_TEXT_CHAR = 3'd3;
   localparam code_type CMD_TEXT_END  = 3'd4;

   localparam sym_type  LAST_SYM   = sym_type'(NSYM - 1);
   localparam sym_type  FULL_COUNT = sym_type'(NSYM);
   localparam sym_type  PAD_SYM    = 6'd23;   // 'X'
   localparam sym_type  DIGIT_BASE = 6'd26;

   localparam char_type ASCII_UP_A = 8'h41;
   localparam char_type ASCII_UP_Z = 8'h5A;
   localparam char_type ASCII_LO_A = 8'h61;
   localparam char_type ASCII_LO_Z = 8'h7A;
   localparam char_type ASCII_ZERO = 8'h30;
   localparam char_type ASCII_NINE = 8'h39;

   typedef struct packed {
      logic latch;
      logic clear;
      logic place_key;
      logic walk_start;
      logic walk_step;
      logic set_pending;
      logic pos_read;
      logic pad;
      logic grid_read;
      logic out_second;
   } pf6_cmd_type;

   typedef struct packed {
      code_type cmd_code;
      logic     sym_ok;
      logic     grid_ready;
      logic     pending_valid;
      logic     walk_last;
   } pf6_status_type;

   function automatic logic is_alnum(input char_type c);
      return (c >= ASCII_UP_A && c <= ASCII_UP_Z) ||
             (c >= ASCII_LO_A && c <= ASCII_LO_Z) ||
             (c >= ASCII_ZERO && c <= ASCII_NINE);
   endfunction

   function automatic sym_type to_sym(input char_type c);
      sym_type s;
      if (c >= ASCII_UP_A && c <= ASCII_UP_Z) begin
         s = sym_type'(c - ASCII_UP_A);
      end else if (c >= ASCII_LO_A && c <= ASCII_LO_Z) begin
         s = sym_type'(c - ASCII_LO_A);
      end else begin
         s = sym_type'(c - ASCII_ZERO) + DIGIT_BASE;
      end
      return s;
   endfunction

   function automatic char_type to_ascii(input sym_type s);
      char_type c;
      if (s < DIGIT_BASE) begin
         c = ASCII_UP_A + char_type'(s);
      end else begin
         c = ASCII_ZERO + char_type'(s - DIGIT_BASE);
      end
      return c;
   endfunction

   // pos / 6 for pos < 36 as a multiply by 43/256
   function automatic logic [2:0] pos_row(input sym_type pos);
      logic [11:0] prod;
      prod = 12'(pos) * 12'd43;
      return prod[10:8];
   endfunction

   function automatic logic [2:0] pos_col(input sym_type pos);
      sym_type base;
      base = sym_type'(pos_row(pos)) * sym_type'(SIDE);
      return 3'(pos - base);
   endfunction

   function automatic sym_type cell_of(input logic [2:0] row, input logic [2:0] col);
      return sym_type'(row) * sym_type'(SIDE) + sym_type'(col);
   endfunction

endpackage

/* src/pf6_channels.sv */
interface pf6_req_if
   import pf6_pkg::*;
();
   logic     valid;
   logic     ready;
   code_type command;
   char_type char_code;

   modport source (output valid, output command, output char_code, input ready);
   modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface pf6_rsp_if
   import pf6_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type out_char;
   logic     pair_last;

   modport source (output valid, output out_char, output pair_last, input ready);
   modport sink   (input valid, input out_char, input pair_last, output ready);
endinterface

/* src/pf6_ctrl.sv */
module pf6_ctrl
   import pf6_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  pf6_status_type status,
   output pf6_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_FILL   = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_OUT0   = 3'd4;
   localparam logic [2:0] ST_OUT1   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            unique case (status.cmd_code)
               CMD_START_KEY: cmd.clear = 1'b1;
               CMD_KEY_CHAR:  cmd.place_key = !status.grid_ready && status.sym_ok;
               CMD_KEY_END: begin
                  if (!status.grid_ready) begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_FILL;
                  end
               end
               CMD_TEXT_CHAR: begin
                  if (status.grid_ready && status.sym_ok) begin
                     if (status.pending_valid) begin
                        cmd.pos_read = 1'b1;
                        state_in     = ST_LOOKUP;
                     end else begin
                        cmd.set_pending = 1'b1;
                     end
                  end
               end
               CMD_TEXT_END: begin
                  if (status.grid_ready && status.pending_valid) begin
                     cmd.pos_read = 1'b1;
                     cmd.pad      = 1'b1;
                     state_in     = ST_LOOKUP;
                  end
               end
               default: ;
            endcase
         end
         ST_FILL: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            cmd.grid_read = 1'b1;
            state_in      = ST_OUT0;
         end
         ST_OUT0: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            rsp_valid      = 1'b1;
            cmd.out_second = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/pf6_datapath.sv */
module pf6_datapath
   import pf6_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  code_type       req_command,
   input  char_type       req_char_code,
   input  pf6_cmd_type    cmd,
   output pf6_status_type status,
   output char_type       rsp_out_char,
   output logic           rsp_pair_last
);

   sym_type grid_mem [NSYM];
   sym_type pos_mem  [NSYM];

   logic [NSYM-1:0] used_ff,  used_in;
   sym_type         fill_ff,  fill_in;
   logic            ready_ff, ready_in;
   sym_type         pend_sym_ff, pend_sym_in;
   logic            pend_ok_ff,  pend_ok_in;
   sym_type         walk_ff,  walk_in;
   code_type        code_ff,  code_in;
   sym_type         sym_ff,   sym_in;
   logic            sym_ok_ff, sym_ok_in;

   sym_type pos_a_ff, pos_b_ff;
   sym_type cell_a_ff, cell_b_ff;

   sym_type place_sym;
   logic    place_en;
   sym_type pos_b_addr;
   sym_type cell_a, cell_b;

   assign place_sym  = cmd.walk_step ? walk_ff : sym_ff;
   assign place_en   = (cmd.place_key || cmd.walk_step) && !used_ff[place_sym] &&
                       (fill_ff != FULL_COUNT);
   assign pos_b_addr = cmd.pad ? PAD_SYM : sym_ff;
   assign cell_a     = cell_of(pos_row(pos_a_ff), pos_col(pos_b_ff));
   assign cell_b     = cell_of(pos_row(pos_b_ff), pos_col(pos_a_ff));

   always_comb begin
      used_in     = used_ff;
      fill_in     = fill_ff;
      ready_in    = ready_ff;
      pend_sym_in = pend_sym_ff;
      pend_ok_in  = pend_ok_ff;
      walk_in     = walk_ff;
      code_in     = code_ff;
      sym_in      = sym_ff;
      sym_ok_in   = sym_ok_ff;
      if (cmd.latch) begin
         code_in   = req_command;
         sym_in    = to_sym(req_char_code);
         sym_ok_in = is_alnum(req_char_code);
      end
      if (cmd.clear) begin
         used_in    = '0;
         fill_in    = '0;
         ready_in   = 1'b0;
         pend_ok_in = 1'b0;
      end
      if (place_en) begin
         used_in[place_sym] = 1'b1;
         fill_in            = fill_ff + 1'b1;
      end
      if (cmd.walk_start) begin
         walk_in = '0;
      end
      if (cmd.walk_step) begin
         walk_in = walk_ff + 1'b1;
         if (walk_ff == LAST_SYM) begin
            ready_in   = 1'b1;
            pend_ok_in = 1'b0;
         end
      end
      if (cmd.set_pending) begin
         pend_sym_in = sym_ff;
         pend_ok_in  = 1'b1;
      end
      if (cmd.pos_read) begin
         pend_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         fill_ff    <= '0;
         ready_ff   <= 1'b0;
         pend_ok_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         fill_ff    <= fill_in;
         ready_ff   <= ready_in;
         pend_ok_ff <= pend_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_sym_ff <= pend_sym_in;
      walk_ff     <= walk_in;
      code_ff     <= code_in;
      sym_ff      <= sym_in;
      sym_ok_ff   <= sym_ok_in;
   end

   always_ff @(posedge clock) begin
      if (place_en) begin
         grid_mem[fill_ff]  <= place_sym;
         pos_mem[place_sym] <= fill_ff;
      end
      if (cmd.pos_read) begin
         pos_a_ff <= pos_mem[pend_sym_ff];
         pos_b_ff <= pos_mem[pos_b_addr];
      end
      if (cmd.grid_read) begin
         cell_a_ff <= grid_mem[cell_a];
         cell_b_ff <= grid_mem[cell_b];
      end
   end

   assign status.cmd_code      = code_ff;
   assign status.sym_ok        = sym_ok_ff;
   assign status.grid_ready    = ready_ff;
   assign status.pending_valid = pend_ok_ff;
   assign status.walk_last     = (walk_ff == LAST_SYM);

   assign rsp_out_char  = to_ascii(cmd.out_second ? cell_b_ff : cell_a_ff);
   assign rsp_pair_last = cmd.out_second;

endmodule

/* src/playfair_6x6_cipher.sv */
// 6x6 Playfair cipher over A-Z then 0-9, rectangle rule only; encrypt and
// decrypt are the same operation.
// req_if carries one word (command, char_code): start key, key char, key end,
// text char or text end. rsp_if carries ciphered characters, two per pair,
// with pair_last high on the second one.
// Timing: the block takes one request word at a time. A word that gives no
// result passes through accept and decode. Key end also runs the fill walk,
// which steps once per symbol over all 36 symbols, placing the unused
// ones into the grid. A text word that closes a pair shows its first result
// after decode, a position lookup and a grid lookup (both through registered
// memory reads), and the second one the cycle after the first is taken;
// req_if.ready returns the cycle after the second is taken.
// Reset clears the grid status, the symbol marks and any open pair; the grid
// itself keeps stale contents and is only read after a full key load.
// When the receiver stalls, the result word holds on rsp_if and no new
// request word is taken until both results of the pair have been taken.
module playfair_6x6_cipher
   import pf6_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pf6_req_if.sink   req_if,
   pf6_rsp_if.source rsp_if
);

   pf6_cmd_type    cmd;
   pf6_status_type status;

   // Sequence each word: decode, fill walk, two lookups, two results.
   pf6_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the grid, symbol positions, fill state and the open pair.
   pf6_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_if.command),
      .req_char_code (req_if.char_code),
      .cmd           (cmd),
      .status        (status),
      .rsp_out_char  (rsp_if.out_char),
      .rsp_pair_last (rsp_if.pair_last)
   );

endmodule

/* src/pf6_checker.sv */
module pf6_checker
   import pf6_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input char_type rsp_out_char,
   input logic     rsp_pair_last
);

   // A stalled result word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // The second half of a pair follows right after the first is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_pair_last |=> rsp_valid && rsp_pair_last)
      else $error("second half of pair missing");

   // After the second half, the output goes quiet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_pair_last |=> !rsp_valid)
      else $error("extra result word after pair");

   // No request word is taken while a result is still offered.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken during result");

   // Every result is an upper-case letter or a digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char >= ASCII_UP_A && rsp_out_char <= ASCII_UP_Z) ||
                    (rsp_out_char >= ASCII_ZERO && rsp_out_char <= ASCII_NINE))
      else $error("result character out of alphabet");

endmodule

bind playfair_6x6_cipher pf6_checker u_pf6_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_out_char  (rsp_if.out_char),
   .rsp_pair_last (rsp_if.pair_last)
);

/* tb/sv/testbench.sv */
module testbench
   import pf6_pkg::*;
();

   // One ciphered character as it should leave the block.
   typedef struct packed {
      char_type out_char;
      logic     pair_last;
   } cipher_char_type;

   // Keeps its own copy of the key grid and the open pair. note_word follows each
   // accepted request word; check_char pops the oldest ciphered character due.
   class cipher_board_type;
      sym_type         grid_sym [NSYM];
      sym_type         sym_cell [NSYM];
      bit              placed   [NSYM];
      int              filled;
      bit              grid_done;
      sym_type         held_sym;
      bit              held;
      cipher_char_type due_chars[$];
      int              errors;
      int              chars_checked;
      int              key_loads;

      function new();
         foreach (placed[k]) begin
            placed[k]   = 1'b0;
            grid_sym[k] = '0;
            sym_cell[k] = '0;
         end
         filled        = 0;
         grid_done     = 1'b0;
         held_sym      = '0;
         held          = 1'b0;
         errors        = 0;
         chars_checked = 0;
         key_loads     = 0;
      endfunction

      // Fold a byte to a grid symbol; return 0 for anything but A-Z, a-z, 0-9.
      function bit fold(input char_type ch, output sym_type s);
         s = '0;
         if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
            s = sym_type'(ch - ASCII_UP_A);
            return 1'b1;
         end
         if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
            s = sym_type'(ch - ASCII_LO_A);
            return 1'b1;
         end
         if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
            s = sym_type'(ch - ASCII_ZERO) + DIGIT_BASE;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function char_type glyph(input sym_type s);
         if (s < DIGIT_BASE) return ASCII_UP_A + char_type'(s);
         return ASCII_ZERO + char_type'(s - DIGIT_BASE);
      endfunction

      function void place(input sym_type s);
         if (placed[s] || filled >= NSYM) return;
         grid_sym[filled] = s;
         sym_cell[s]      = sym_type'(filled);
         placed[s]        = 1'b1;
         filled++;
      endfunction

      // Rectangle rule: first gets p's row and q's column, second the reverse.
      function void cipher_pair(input sym_type p, input sym_type q);
         int row_p, col_p, row_q, col_q;
         row_p = int'(sym_cell[p]) / SIDE;
         col_p = int'(sym_cell[p]) % SIDE;
         row_q = int'(sym_cell[q]) / SIDE;
         col_q = int'(sym_cell[q]) % SIDE;
         due_chars.push_back('{glyph(grid_sym[row_p * SIDE + col_q]), 1'b0});
         due_chars.push_back('{glyph(grid_sym[row_q * SIDE + col_p]), 1'b1});
      endfunction

      function void note_word(input code_type cmd, input char_type ch);
         sym_type s;
         case (cmd)
            CMD_START_KEY: begin
               foreach (placed[k]) placed[k] = 1'b0;
               filled    = 0;
               grid_done = 1'b0;
               held      = 1'b0;
            end
            CMD_KEY_CHAR: begin
               if (!grid_done && fold(ch, s)) place(s);
            end
            CMD_KEY_END: begin
               if (!grid_done) begin
                  for (int k = 0; k < NSYM; k++) place(sym_type'(k));
                  grid_done = 1'b1;
                  held      = 1'b0;
                  key_loads++;
               end
            end
            CMD_TEXT_CHAR: begin
               if (grid_done && fold(ch, s)) begin
                  if (!held) begin
                     held_sym = s;
                     held     = 1'b1;
                  end else begin
                     held = 1'b0;
                     cipher_pair(held_sym, s);
                  end
               end
            end
            CMD_TEXT_END: begin
               if (grid_done && held) begin
                  held = 1'b0;
                  cipher_pair(held_sym, PAD_SYM);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_char(input char_type got_char, input logic got_last);
         cipher_char_type want;
         chars_checked++;
         if (due_chars.size() == 0) begin
            $error("unexpected cipher word: out_char %h pair_last %b", got_char, got_last);
            errors++;
            return;
         end
         want = due_chars.pop_front();
         if (got_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, got_char);
            errors++;
         end
         if (got_last !== want.pair_last) begin
            $error("pair_last: expected %b, got %b", want.pair_last, got_last);
            errors++;
         end
      endfunction
   endclass

   localparam int WORD_TARGET = 550;
   localparam int STALL_LIMIT = 2000;   // key end walk plus long random gaps, many times over
   localparam int TAIL_CYCLES = 50;

   logic clock;
   logic reset;

   pf6_req_if req_ch();
   pf6_rsp_if rsp_ch();

   cipher_board_type board = new();

   bit steady;          // high while neither side idles
   int words_sent;
   int stall_cycles = 0;

   playfair_6x6_cipher dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Note each accepted request word in the predictor.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         board.note_word(req_ch.command, req_ch.char_code);
      end
   end

   // Check each accepted cipher word against the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_char(rsp_ch.out_char, rsp_ch.pair_last);
      end
   end

   // Receiver: stall about a third of the time, except in the steady stretch.
   always @(posedge clock) begin
      rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offer one request word; idle at random first, then hold it until taken.
   task automatic send_word(input code_type cmd, input char_type ch);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.char_code <= ch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (cmd <= CMD_TEXT_END) words_sent++;
   endtask

   // Hold the sender until every cipher word due has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.due_chars.size() != 0) @(posedge clock);
   endtask

   // Key characters: mostly letters of both cases and digits, now and then any byte.
   function automatic char_type pick_key_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return ASCII_UP_A + char_type'($urandom_range(0, 25));
      if (pick < 65) return ASCII_LO_A + char_type'($urandom_range(0, 25));
      if (pick < 85) return ASCII_ZERO + char_type'($urandom_range(0, 9));
      return char_type'($urandom_range(0, 255));
   endfunction

   // Text characters: alphanumerics with a little punctuation and raw bytes to drop.
   function automatic char_type pick_text_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return ASCII_UP_A + char_type'($urandom_range(0, 25));
      if (pick < 70) return ASCII_LO_A + char_type'($urandom_range(0, 25));
      if (pick < 90) return ASCII_ZERO + char_type'($urandom_range(0, 9));
      return char_type'($urandom_range(0, 255));
   endfunction

   // One well-formed session: load a key, then cipher one or more messages.
   task automatic run_session();
      int key_len;
      int messages;
      int text_len;
      key_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 8);
      messages = $urandom_range(1, 3);
      send_word(CMD_START_KEY, char_type'($urandom_range(0, 255)));
      repeat (key_len) send_word(CMD_KEY_CHAR, pick_key_char());
      // text while the grid is still open must be dropped
      if ($urandom_range(0, 7) == 0) send_word(CMD_TEXT_CHAR, pick_text_char());
      send_word(CMD_KEY_END, char_type'($urandom_range(0, 255)));
      // late key words once the grid is full must be dropped too
      if ($urandom_range(0, 7) == 0) begin
         send_word(CMD_KEY_CHAR, pick_key_char());
         send_word(CMD_KEY_END, char_type'($urandom_range(0, 255)));
      end
      repeat (messages) begin
         text_len = $urandom_range(1, 16);
         repeat (text_len) send_word(CMD_TEXT_CHAR, pick_text_char());
         if ($urandom_range(0, 4) != 0) send_word(CMD_TEXT_END, char_type'($urandom_range(0, 255)));
      end
   endtask

   // Noise: any command code, unknown ones included, with any byte.
   task automatic run_noise();
      repeat ($urandom_range(1, 4)) begin
         send_word(code_type'($urandom_range(0, 7)), char_type'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      steady           = 1'b0;
      words_sent       = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_START_KEY;
      req_ch.char_code <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Text before any grid exists: drop both.
      send_word(CMD_TEXT_CHAR, "A");
      send_word(CMD_TEXT_END, 8'h00);

      // Key "ZA90P" from mixed case with a repeat and two non-alphanumerics.
      send_word(CMD_START_KEY, 8'hFF);
      send_word(CMD_KEY_CHAR, "z");
      send_word(CMD_KEY_CHAR, "A");
      send_word(CMD_KEY_CHAR, "9");
      send_word(CMD_KEY_CHAR, "0");
      send_word(CMD_KEY_CHAR, "p");
      send_word(CMD_KEY_CHAR, "P");
      send_word(CMD_KEY_CHAR, 8'hFF);
      send_word(CMD_KEY_CHAR, 8'h00);
      send_word(CMD_TEXT_CHAR, "x");
      send_word(CMD_KEY_END, 8'h00);

      // Grid is full: a further key char and key end change nothing.
      send_word(CMD_KEY_CHAR, "q");
      send_word(CMD_KEY_END, 8'hFF);

      // Same row (Z and 9), same column (Z and C), a doubled symbol.
      send_word(CMD_TEXT_CHAR, "Z");
      send_word(CMD_TEXT_CHAR, "9");
      send_word(CMD_TEXT_CHAR, "z");
      send_word(CMD_TEXT_CHAR, "c");
      send_word(CMD_TEXT_CHAR, "a");
      send_word(CMD_TEXT_CHAR, "A");
      // A dropped byte inside a pair, then an odd tail padded with X.
      send_word(CMD_TEXT_CHAR, "b");
      send_word(CMD_TEXT_CHAR, "@");
      send_word(CMD_TEXT_END, 8'h55);
      send_word(CMD_TEXT_END, 8'hAA);

      // Unknown command codes do nothing.
      send_word(code_type'(5), "0");
      send_word(code_type'(6), 8'h80);
      send_word(code_type'(7), 8'h7F);

      drain();

      // Random part; a steady stretch in the middle, occasional full drains.
      while (words_sent < WORD_TARGET) begin
         steady = (words_sent >= 220 && words_sent < 330);
         if ($urandom_range(0, 9) < 8) run_session();
         else run_noise();
         if ($urandom_range(0, 5) == 0) drain();
      end
      steady = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request words over %0d key loads, %0d cipher words checked.",
               words_sent, board.key_loads, board.chars_checked);
      $display("Keys mixed case, repeats and dropped bytes; text with pads and idle gaps.");
      if (board.errors == 0 && board.due_chars.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (board.due_chars.size() != 0) begin
            $error("%0d cipher words never arrived", board.due_chars.size());
         end
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
src/pf6_pkg.sv
src/pf6_channels.sv
src/pf6_ctrl.sv
src/pf6_datapath.sv
src/playfair_6x6_cipher.sv
src/pf6_checker.sv
tb/sv/testbench.sv
